@@ design/simq_pkg.sv @@
// Shared types and constants for the sequence-indexed message queue.
// No dependencies.
package simq_pkg;
    localparam logic [2:0] ACT_PUSH    = 3'd0;
    localparam logic [2:0] ACT_CONSUME = 3'd1;
    localparam logic [2:0] ACT_ACQUIRE = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_DELETE  = 3'd4;
    localparam logic [2:0] ACT_FIND    = 3'd5;
    localparam logic [2:0] ACT_BROWSE  = 3'd6;
    localparam logic [2:0] ACT_UPDACQ  = 3'd7;

    localparam logic [1:0] ST_AVAIL = 2'd0;
    localparam logic [1:0] ST_ACQ   = 2'd1;
    localparam logic [1:0] ST_DEL   = 2'd2;

    // serial order: a before b
    function automatic logic before32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction
endpackage

@@ design/simq_ram.sv @@
// Entry store: status and handle per ring slot, one write and one
// registered read port. Depends on simq_pkg.
module simq_ram
    import simq_pkg::*;
#(
    parameter int AW = 8,
    parameter int HW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wstatus,
    input  logic [HW-1:0] whandle,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rstatus,
    output logic [HW-1:0] rhandle
);
    logic [HW+1:0] mem [2**AW];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wstatus, whandle};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        {rstatus, rhandle} <= mem[raddr];
    end
endmodule

@@ design/sequence_indexed_message_queue.sv @@
// Sequence-indexed message queue, top level. Depends on simq_pkg, simq_ram.
// Find/acquire/release/update-acquired read the entry at the position; a miss skips the read.
// Push writes any padding, then the entry; update-acquired pads at the back or at the front;
// consume/browse read entries in turn until one fits or the end; delete then trims the front.
// One request at a time; the next is taken the cycle after the result register loads.
// Reset (aresetn low, synchronous) empties the queue; the store is not cleared.
module sequence_indexed_message_queue
    import simq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], position[34:3], handle[66:35], unacquired_only[67], zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], position_out[32:1], handle_out[64:33], status_out[66:65],
    // available_total[75:67], overflow[76], zero pad
    output logic [79:0] m_tdata
);
    localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam int HB = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_PADB  = 4'd2;
    localparam logic [3:0] S_PADF  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_RDW   = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_TRIMR = 4'd7;
    localparam logic [3:0] S_TRIMW = 4'd8;
    localparam logic [3:0] S_TRIME = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    act_reg, act_next;
    logic [31:0]   pos_reg, pos_next;
    logic [HANDLE_BITS-1:0] hdl_reg, hdl_next;
    logic          unacq_reg, unacq_next;
    logic [31:0]   front_reg, front_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] avail_reg, avail_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   pad_reg, pad_next;
    logic          ok_reg, ok_next;
    logic [31:0]   po_reg, po_next;
    logic [31:0]   ho_reg, ho_next;
    logic [1:0]    so_reg, so_next;
    logic          ovf_reg, ovf_next;
    logic          mv_reg, mv_next;
    logic [79:0]   mdata_reg, mdata_next;

    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [1:0]             wst, rst;
    logic [HANDLE_BITS-1:0] whd, rhd;

    simq_ram #(.AW(AW), .HW(HANDLE_BITS)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wstatus(wst), .whandle(whd),
        .raddr(raddr), .rstatus(rst), .rhandle(rhd)
    );

    // ring slot of an offset
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b,
                                              input logic [CW-1:0] i);
        logic [CW:0] s;
        s = {1'b0, CW'(b)} + {1'b0, i};
        if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
        return s[AW-1:0];
    endfunction

    logic [31:0] handle32;
    always_comb begin
        handle32 = '0;
        handle32[HB-1:0] = rhd[HB-1:0];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // shared offset/compare terms
    logic [31:0] off32, last_pos, gap, pos1;
    logic        bef, hit;
    logic [CW-1:0] offi;
    logic [32:0] need;

    always_comb begin
        pos1     = pos_reg + 32'd1;
        bef      = before32((act_reg == ACT_BROWSE) ? pos1 : pos_reg, front_reg);
        off32    = (((act_reg == ACT_BROWSE) ? pos1 : pos_reg) - front_reg);
        if (count_reg == '0 || bef) off32 = '0;
        hit      = (off32 < 32'(count_reg));
        offi     = hit ? off32[CW-1:0] : '0;
        last_pos = front_reg + 32'(count_reg) - 32'd1;
        gap      = pos_reg - last_pos;
        if (count_reg == '0 || gap[31] || gap <= 32'd1) gap = '0;
        else gap = gap - 32'd1;
        need     = 33'(count_reg) + 33'(gap) + 33'd1;
    end

    // sequencer
    always_comb begin
        state_next = state_reg; act_next = act_reg; pos_next = pos_reg;
        hdl_next = hdl_reg; unacq_next = unacq_reg; front_next = front_reg;
        base_next = base_reg; count_next = count_reg; head_next = head_reg;
        avail_next = avail_reg; idx_next = idx_reg; pad_next = pad_reg;
        ok_next = ok_reg; po_next = po_reg; ho_next = ho_reg; so_next = so_reg;
        ovf_next = ovf_reg; mv_next = mv_reg; mdata_next = mdata_reg;
        we = 1'b0; waddr = slot_of(base_reg, idx_reg); wst = ST_DEL; whd = '0;
        raddr = slot_of(base_reg, idx_reg);

        if (mv_reg && m_tready) mv_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    act_next   = s_tdata[2:0];
                    pos_next   = s_tdata[34:3];
                    hdl_next   = HANDLE_BITS'(s_tdata[66:35]);
                    unacq_next = s_tdata[67];
                    ok_next = 1'b0; po_next = '0; ho_next = '0; so_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                priority if (act_reg == ACT_PUSH) begin
                    if (need > 33'(QUEUE_DEPTH)) begin
                        ovf_next = 1'b1; state_next = S_OUT;
                    end else begin
                        if (count_reg == '0) front_next = pos_reg;
                        pad_next = gap; state_next = S_PADB;
                    end
                end else if (act_reg == ACT_CONSUME) begin
                    idx_next = head_reg; state_next = S_RD;
                end else if (act_reg == ACT_UPDACQ) begin
                    if (count_reg != '0 && before32(pos_reg, front_reg)) begin
                        if (33'(count_reg) + 33'(front_reg - pos_reg)
                                > 33'(QUEUE_DEPTH)) begin
                            ovf_next = 1'b1; state_next = S_OUT;
                        end else begin
                            pad_next = front_reg - pos_reg; state_next = S_PADF;
                        end
                    end else if (hit) begin
                        idx_next = offi; state_next = S_RD;
                    end else if (need > 33'(QUEUE_DEPTH)) begin
                        ovf_next = 1'b1; state_next = S_OUT;
                    end else begin
                        if (count_reg == '0) front_next = pos_reg;
                        pad_next = gap; state_next = S_PADB;
                    end
                end else if (act_reg == ACT_ACQUIRE && (count_reg == '0 || bef)) begin
                    state_next = S_OUT;
                end else begin
                    if (hit) begin
                        idx_next = offi; state_next = S_RD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            // append padding then the new entry
            S_PADB: begin
                we = 1'b1;
                waddr = slot_of(base_reg, count_reg);
                count_next = count_reg + 1'b1;
                if (pad_reg != '0) begin
                    pad_next = pad_reg - 32'd1;
                end else begin
                    wst = (act_reg == ACT_PUSH) ? ST_AVAIL : ST_ACQ;
                    whd = hdl_reg;
                    if (act_reg == ACT_PUSH) begin
                        avail_next = avail_reg + 1'b1;
                        if (head_reg >= count_reg + 1'b1) head_next = count_reg;
                    end
                    ok_next = 1'b1;
                    po_next = front_reg + 32'(count_reg);
                    ho_next = '0;
                    ho_next[HB-1:0] = hdl_reg[HB-1:0];
                    so_next = wst;
                    state_next = S_OUT;
                end
            end
            // prepend padding until front reaches position
            S_PADF: begin
                if (pad_reg != '0) begin
                    we = 1'b1;
                    base_next = (base_reg == '0) ? AW'(QUEUE_DEPTH - 1) : base_reg - 1'b1;
                    waddr = base_next;
                    front_next = front_reg - 32'd1;
                    count_next = count_reg + 1'b1;
                    pad_next = pad_reg - 32'd1;
                end else begin
                    idx_next = '0; state_next = S_RD;
                end
            end
            S_RD: begin
                if ((act_reg == ACT_CONSUME || act_reg == ACT_BROWSE)
                        && idx_reg >= count_reg) begin
                    if (act_reg == ACT_CONSUME) head_next = idx_reg;
                    state_next = S_OUT;
                end else begin
                    state_next = S_RDW;
                end
            end
            S_RDW: state_next = S_EVAL;
            S_EVAL: begin
                state_next = S_OUT;
                unique case (act_reg)
                    ACT_CONSUME: begin
                        if (rst == ST_AVAIL) begin
                            we = 1'b1; wst = ST_ACQ; whd = rhd;
                            head_next = idx_reg + 1'b1;
                            avail_next = avail_reg - 1'b1;
                            ok_next = 1'b1; so_next = ST_ACQ;
                        end else begin
                            idx_next = idx_reg + 1'b1; state_next = S_RD;
                        end
                    end
                    ACT_ACQUIRE: begin
                        if (rst == ST_AVAIL) begin
                            we = 1'b1; wst = ST_ACQ; whd = rhd;
                            avail_next = avail_reg - 1'b1;
                            ok_next = 1'b1; so_next = ST_ACQ;
                        end
                    end
                    ACT_RELEASE: begin
                        if (rst == ST_ACQ) begin
                            we = 1'b1; wst = ST_AVAIL; whd = rhd;
                            if (head_reg > idx_reg) head_next = idx_reg;
                            avail_next = avail_reg + 1'b1;
                            ok_next = 1'b1; so_next = ST_AVAIL;
                        end
                    end
                    ACT_DELETE: begin
                        if (rst != ST_DEL) begin
                            we = 1'b1; wst = ST_DEL; whd = rhd;
                            ok_next = 1'b1; state_next = S_TRIMR;
                        end
                    end
                    ACT_FIND: begin
                        ok_next = 1'b1; so_next = rst;
                    end
                    ACT_BROWSE: begin
                        if (rst == ST_AVAIL || (!unacq_reg && rst == ST_ACQ)) begin
                            ok_next = 1'b1; so_next = rst;
                        end else begin
                            idx_next = idx_reg + 1'b1; state_next = S_RD;
                        end
                    end
                    default: begin
                        we = 1'b1; wst = ST_ACQ; whd = hdl_reg;
                        ok_next = 1'b1; so_next = ST_ACQ;
                    end
                endcase
                po_next = front_reg + 32'(idx_reg);
                ho_next = (act_reg == ACT_UPDACQ) ? 32'(hdl_reg) & 32'(handle32 | ~32'd0)
                                                  : handle32;
                if (act_reg == ACT_UPDACQ) begin
                    ho_next = '0;
                    ho_next[HB-1:0] = hdl_reg[HB-1:0];
                end
                if (act_reg == ACT_DELETE || !ok_next) begin
                    po_next = '0; ho_next = '0; so_next = '0;
                end
            end
            // trim deleted entries off the front
            S_TRIMR: begin
                raddr = base_reg;
                if (count_reg == '0) state_next = S_OUT;
                else state_next = S_TRIMW;
            end
            S_TRIMW: begin
                raddr = base_reg;
                state_next = S_TRIME;
            end
            S_TRIME: begin
                if (rst == ST_DEL) begin
                    base_next = (base_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : base_reg + 1'b1;
                    front_next = front_reg + 32'd1;
                    count_next = count_reg - 1'b1;
                    if (head_reg != '0) head_next = head_reg - 1'b1;
                    state_next = S_TRIMR;
                end else begin
                    state_next = S_OUT;
                end
            end
            // load the output register once the previous result is gone
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    mdata_next = {3'b0, ovf_reg, 9'(avail_reg), so_reg, ho_reg,
                                  po_reg, ok_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; front_reg <= '0; base_reg <= '0;
            count_reg <= '0; head_reg <= '0; avail_reg <= '0; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; front_reg <= front_next; base_reg <= base_next;
            count_reg <= count_next; head_reg <= head_next; avail_reg <= avail_next;
            mv_reg <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg <= act_next; pos_reg <= pos_next; hdl_reg <= hdl_next;
        unacq_reg <= unacq_next; idx_reg <= idx_next; pad_reg <= pad_next;
        ok_reg <= ok_next; po_reg <= po_next; ho_reg <= ho_next;
        so_reg <= so_next; ovf_reg <= ovf_next; mdata_reg <= mdata_next;
    end
endmodule

@@ dv/tb_sequence_indexed_message_queue.sv @@
// Testbench for the sequence-indexed message queue: directed table, then random requests.
// Depends on simq_pkg and sequence_indexed_message_queue; results are checked by a
// behavioral copy of the queue, or against the expected result of a typed table row.
`timescale 1ns / 1ps

module tb_sequence_indexed_message_queue;
    import simq_pkg::*;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 500;

    typedef struct packed {
        logic        ok;
        logic [31:0] pos;
        logic [31:0] hnd;
        logic [1:0]  st;
        logic [8:0]  avail;
        logic        ovf;
    } qresult_t;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] pos;
        logic [31:0] hnd;
        logic        unacq;
        bit          typed;
        qresult_t    res;
    } qrequest_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    // queue state mirror
    logic [1:0]  mq_status [DEPTH];
    logic [31:0] mq_handle [DEPTH];
    logic [31:0] mq_front;
    logic [7:0]  mq_base;
    int unsigned mq_count;
    int unsigned mq_head;
    int unsigned mq_avail;

    qresult_t    pending_results[$];
    int          fail_count;
    int          idle_cycles;
    bit          ready_always;

    sequence_indexed_message_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [7:0] ring_slot(logic [31:0] i);
        return mq_base + i[7:0];
    endfunction

    function automatic logic [31:0] offset_of(logic [31:0] p);
        if (mq_count == 0 || is_earlier(p, mq_front))
            return 32'd0;
        return p - mq_front;
    endfunction

    function automatic logic [31:0] tail_gap(logic [31:0] p);
        logic [31:0] d;
        d = p - (mq_front + mq_count - 1);
        if (!d[31] && d > 1)
            return d - 1;
        return 32'd0;
    endfunction

    function automatic void append_entry(logic [1:0] st, logic [31:0] h);
        logic [7:0] s;
        s = ring_slot(mq_count);
        mq_status[s] = st;
        mq_handle[s] = h;
        mq_count++;
    endfunction

    function automatic void fill_entry_result(ref qresult_t r, input logic [31:0] i);
        logic [7:0] s;
        s = ring_slot(i);
        r.ok = 1'b1;
        r.pos = mq_front + i;
        r.hnd = mq_handle[s];
        r.st = mq_status[s];
    endfunction

    // Appends at p (push or update-acquired past the end); returns 0 on overflow.
    function automatic bit place_at_tail(ref qresult_t r, input logic [31:0] p,
                                         input logic [31:0] h, input logic [1:0] st);
        logic [31:0] pad;
        pad = (mq_count > 0) ? tail_gap(p) : 32'd0;
        if (longint'(mq_count) + longint'(pad) + 1 > DEPTH)
            return 1'b0;
        if (mq_count == 0)
            mq_front = p;
        for (longint k = 0; k < pad; k++)
            append_entry(ST_DEL, 32'd0);
        append_entry(st, h);
        return 1'b1;
    endfunction

    // Advances the mirror by one request and returns the result it produces.
    function automatic qresult_t queue_apply(qrequest_t q);
        qresult_t    r;
        logic [31:0] i;
        logic [31:0] n;
        logic [7:0]  s;
        r = '0;
        case (q.act)
            ACT_PUSH: begin
                if (!place_at_tail(r, q.pos, q.hnd, ST_AVAIL)) begin
                    r.ovf = 1'b1;
                end else begin
                    if (mq_head >= mq_count)
                        mq_head = mq_count - 1;
                    mq_avail++;
                    fill_entry_result(r, mq_count - 1);
                end
            end
            ACT_CONSUME: begin
                while (mq_head < mq_count) begin
                    i = mq_head;
                    mq_head++;
                    s = ring_slot(i);
                    if (mq_status[s] == ST_AVAIL) begin
                        mq_status[s] = ST_ACQ;
                        mq_avail--;
                        fill_entry_result(r, i);
                        break;
                    end
                end
            end
            ACT_ACQUIRE: begin
                if (mq_count != 0 && !is_earlier(q.pos, mq_front)) begin
                    i = offset_of(q.pos);
                    s = ring_slot(i);
                    if (i < mq_count && mq_status[s] == ST_AVAIL) begin
                        mq_status[s] = ST_ACQ;
                        mq_avail--;
                        fill_entry_result(r, i);
                    end
                end
            end
            ACT_RELEASE: begin
                i = offset_of(q.pos);
                s = ring_slot(i);
                if (i < mq_count && mq_status[s] == ST_ACQ) begin
                    if (mq_head > i)
                        mq_head = i;
                    mq_status[s] = ST_AVAIL;
                    mq_avail++;
                    fill_entry_result(r, i);
                end
            end
            ACT_DELETE: begin
                i = offset_of(q.pos);
                s = ring_slot(i);
                if (i < mq_count && mq_status[s] != ST_DEL) begin
                    mq_status[s] = ST_DEL;
                    // trim deleted entries off the front
                    while (mq_count > 0 && mq_status[mq_base] == ST_DEL) begin
                        mq_base++;
                        mq_front++;
                        mq_count--;
                        if (mq_head > 0)
                            mq_head--;
                    end
                    r.ok = 1'b1;
                end
            end
            ACT_FIND: begin
                i = offset_of(q.pos);
                if (i < mq_count)
                    fill_entry_result(r, i);
            end
            ACT_BROWSE: begin
                i = offset_of(q.pos + 1);
                while (i < mq_count) begin
                    s = ring_slot(i);
                    if (mq_status[s] == ST_AVAIL || (!q.unacq && mq_status[s] == ST_ACQ)) begin
                        fill_entry_result(r, i);
                        break;
                    end
                    i++;
                end
            end
            ACT_UPDACQ: begin
                r.ovf = 1'b0;
                if (mq_count > 0 && is_earlier(q.pos, mq_front)) begin
                    n = mq_front - q.pos;
                    if (longint'(mq_count) + longint'(n) > DEPTH) begin
                        r.ovf = 1'b1;
                    end else begin
                        // pad the front down to the position
                        for (longint k = 0; k < n; k++) begin
                            mq_base--;
                            mq_front--;
                            mq_status[mq_base] = ST_DEL;
                            mq_handle[mq_base] = 32'd0;
                            mq_count++;
                        end
                    end
                end
                if (!r.ovf) begin
                    i = offset_of(q.pos);
                    if (i < mq_count) begin
                        s = ring_slot(i);
                        mq_status[s] = ST_ACQ;
                        mq_handle[s] = q.hnd;
                        fill_entry_result(r, i);
                    end else if (!place_at_tail(r, q.pos, q.hnd, ST_ACQ)) begin
                        r.ovf = 1'b1;
                    end else begin
                        fill_entry_result(r, mq_count - 1);
                    end
                end
            end
            default: ;
        endcase
        r.avail = mq_avail[8:0];
        return r;
    endfunction

    // Random request shaped around the live range; mode 0 mixed, 1 filling, 2 draining.
    function automatic qrequest_t random_request(int mode);
        qrequest_t   q;
        logic [31:0] last;
        int          pick;
        q = '{default: '0};
        pick = $urandom_range(0, 99);
        if (mode == 1 && pick < 55)
            q.act = ACT_PUSH;
        else if (mode == 2 && pick < 40)
            q.act = ACT_DELETE;
        else if (mode == 2 && pick < 60)
            q.act = ACT_CONSUME;
        else
            q.act = 3'($urandom_range(0, 7));
        q.hnd = $urandom;
        q.unacq = 1'($urandom_range(0, 1));
        last = mq_front + mq_count - 1;
        if (mq_count == 0) begin
            q.pos = $urandom;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: q.pos = mq_front + $urandom_range(0, mq_count + 2) - 2;
                6, 7:             q.pos = last + $urandom_range(1, 4);
                8:                q.pos = mq_front - $urandom_range(1, 4);
                default:          q.pos = $urandom;
            endcase
        end
        return q;
    endfunction

    // Drives one request and updates the mirror when it is accepted.
    task automatic send_request(qrequest_t q);
        qresult_t r;
        int       gap;
        gap = 0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: gap = $urandom_range(1, 3);
            4:          gap = $urandom_range(10, 40);
            default:    gap = 0;
        endcase
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, q.unacq, q.hnd, q.pos, q.act};
        do @(posedge aclk); while (!s_tready);
        r = queue_apply(q);
        pending_results.insert(pending_results.size(), q.typed ? q.res : r);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Result check, receiver stalls and watchdog
    always @(posedge aclk) begin
        qresult_t got;
        qresult_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[66:65],
                       m_tdata[75:67], m_tdata[76]};
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: %h", got);
                    fail_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.pos !== want.pos) begin
                        $error("position_out: expected %h, got %h", want.pos, got.pos);
                        fail_count++;
                    end
                    if (got.hnd !== want.hnd) begin
                        $error("handle_out: expected %h, got %h", want.hnd, got.hnd);
                        fail_count++;
                    end
                    if (got.st !== want.st) begin
                        $error("status_out: expected %0d, got %0d", want.st, got.st);
                        fail_count++;
                    end
                    if (got.avail !== want.avail) begin
                        $error("available_total: expected %0d, got %0d", want.avail, got.avail);
                        fail_count++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
        end
        // receiver back-pressure, mostly short, occasionally long
        if (ready_always || $urandom_range(0, 3) != 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end

    initial begin
        qrequest_t dir_table[$];
        qrequest_t q;
        int        mode;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        ready_always = 1'b0;
        mq_front = '0;
        mq_base = '0;
        mq_count = 0;
        mq_head = 0;
        mq_avail = 0;

        // action, position, handle, unacquired_only, typed, expected result
        dir_table = '{
            '{ACT_CONSUME, 32'd0,   32'd0,        1'b0, 1'b1, '0},
            '{ACT_ACQUIRE, 32'd5,   32'd0,        1'b0, 1'b1, '0},
            '{ACT_FIND,    32'd0,   32'd0,        1'b0, 1'b0, '0},
            '{ACT_PUSH,    32'd100, 32'hFFFFFFFF, 1'b0, 1'b1,
              '{1'b1, 32'd100, 32'hFFFFFFFF, ST_AVAIL, 9'd1, 1'b0}},
            '{ACT_PUSH,    32'd100, 32'd0,        1'b0, 1'b1,
              '{1'b1, 32'd101, 32'd0, ST_AVAIL, 9'd2, 1'b0}},
            '{ACT_PUSH,    32'd105, 32'h12345678, 1'b0, 1'b1,
              '{1'b1, 32'd105, 32'h12345678, ST_AVAIL, 9'd3, 1'b0}},
            '{ACT_PUSH,    32'h1000, 32'd7,       1'b0, 1'b1,
              '{1'b0, 32'd0, 32'd0, ST_AVAIL, 9'd3, 1'b1}},
            '{ACT_FIND,    32'd50,  32'd0,        1'b0, 1'b0, '0},
            '{ACT_BROWSE,  32'd99,  32'd0,        1'b1, 1'b0, '0},
            '{ACT_CONSUME, 32'd0,   32'd0,        1'b0, 1'b0, '0},
            '{ACT_ACQUIRE, 32'd101, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_BROWSE,  32'd99,  32'd0,        1'b0, 1'b0, '0},
            '{ACT_BROWSE,  32'd99,  32'd0,        1'b1, 1'b0, '0},
            '{ACT_RELEASE, 32'd100, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_RELEASE, 32'd102, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_DELETE,  32'd102, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_DELETE,  32'd101, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_DELETE,  32'd100, 32'd0,        1'b0, 1'b0, '0},
            '{ACT_UPDACQ,  32'd97,  32'hAAAA5555, 1'b0, 1'b0, '0},
            '{ACT_UPDACQ,  32'd110, 32'h5555AAAA, 1'b0, 1'b0, '0},
            '{ACT_UPDACQ,  32'd105, 32'h0F0F0F0F, 1'b0, 1'b0, '0},
            '{ACT_UPDACQ,  32'h90000000, 32'd1,   1'b0, 1'b0, '0},
            '{ACT_ACQUIRE, 32'd50,  32'd0,        1'b0, 1'b0, '0},
            '{ACT_FIND,    32'hFFFFFFFF, 32'd0,   1'b0, 1'b0, '0},
            '{ACT_DELETE,  32'd50,  32'd0,        1'b0, 1'b0, '0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (dir_table[k])
            send_request(dir_table[k]);

        // random part; the mode is picked anew every 100 requests
        mode = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) begin
                mode = $urandom_range(0, 2);
                ready_always = ($urandom_range(0, 2) == 0);
            end
            if (n == RANDOM_REQUESTS / 2) begin
                // hold off until every outstanding result is back
                s_tvalid <= 1'b0;
                wait_drained();
            end
            q = random_request(mode);
            send_request(q);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (600) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
